/* sv/assert_macros.svh */
// assertion helpers used by the rtl file line_box_slab_intersection
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// clocked check, off while reset is held
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lbsi check failed");
// clocked check, also active during reset
`define ASSERT_NORST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("lbsi check failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NORST(lbl, prop)
`endif
`endif

/* sv/lbsi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbsi_pkg
// shared widths, payload types and pipeline lengths of the slab clipper
// ----------------------------------------------------------------------------
package lbsi_pkg;
    localparam int CW       = 32;          // coordinate width
    localparam int FB       = 16;          // fraction bits
    localparam int NW       = CW + FB;     // dividend magnitude width
    localparam int PW       = 2 * CW;      // product width
    localparam int AXES     = 3;
    localparam int DIV_LAT  = NW + 2;      // prep, one stage per bit, saturate
    localparam int PIPE_LEN = DIV_LAT + 4; // axis min/max, combine, mul, add

    typedef logic signed [CW-1:0] t_coord;

    localparam t_coord WORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord WORD_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        t_coord origin_x;
        t_coord origin_y;
        t_coord origin_z;
        t_coord direction_x;
        t_coord direction_y;
        t_coord direction_z;
        t_coord box_low_x;
        t_coord box_low_y;
        t_coord box_low_z;
        t_coord box_high_x;
        t_coord box_high_y;
        t_coord box_high_z;
    } t_ray;

    typedef struct packed {
        t_coord entry_x;
        t_coord entry_y;
        t_coord entry_z;
        t_coord exit_x;
        t_coord exit_y;
        t_coord exit_z;
    } t_pts;
endpackage

/* sv/lbsi_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbsi channel interfaces
// valid/ready channels for the ray/box input and the clipped points
// ----------------------------------------------------------------------------
interface lbsi_ray_if;
    import lbsi_pkg::*;
    logic valid;
    logic ready;
    t_ray data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lbsi_pts_if;
    import lbsi_pkg::*;
    logic valid;
    logic ready;
    t_pts data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/line_box_slab_intersection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_box_slab_intersection
// slab clipping of a line against an axis-aligned box, signed Q16.16
// ----------------------------------------------------------------------------
// usage:
//   i_ray carries one line (origin, direction) and one box (low and high
//   corners) per transaction; o_pts returns the entry point at tmin and the
//   exit point at tmax, each coordinate saturated Q16.16.
//   the block is a single-enable pipeline of PIPE_LEN = 54 stages: operand
//   prep, 48 divider stages (one quotient bit each, six dividers side by side),
//   quotient saturation, per-axis min/max, tmin/tmax combine, multiply, and
//   the shift/add/saturate output register.
//   one new transaction is taken every cycle while the output flows.
//   when the receiver stalls with a result waiting, the whole pipe holds and
//   i_ray.ready drops; nothing is lost or repeated. an empty output slot lets
//   the pipe advance even while o_pts.ready is low.
//   synchronous active-low reset clears all valid bits and holds i_ray.ready
//   low; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_box_slab_intersection (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lbsi_ray_if.sink   i_ray,
    lbsi_pts_if.source o_pts
);
    import lbsi_pkg::*;

    typedef struct packed {
        t_coord [AXES-1:0] org;
        t_coord [AXES-1:0] dir;
    } t_ctx;

    logic                w_en;
    logic [PIPE_LEN-1:0] r_vld;
    t_ctx                r_ctx [0:DIV_LAT+2];
    t_ctx                w_ctx_in;

    t_coord w_lo  [AXES];
    t_coord w_hi  [AXES];
    t_coord w_tlo [AXES];
    t_coord w_thi [AXES];

    t_coord r_amin [AXES];
    t_coord r_amax [AXES];
    t_coord r_tmin;
    t_coord r_tmax;
    t_coord n_tmin;
    t_coord n_tmax;
    logic signed [PW-1:0] r_pmin [AXES];
    logic signed [PW-1:0] r_pmax [AXES];
    t_pts   r_out;
    t_pts   n_out;

    // whole pipe advances unless a result waits at the output
    assign w_en        = !r_vld[PIPE_LEN-1] || o_pts.ready;
    assign i_ray.ready = w_en && i_rst_n;

    always_comb begin
        w_ctx_in.org[0] = i_ray.data.origin_x;
        w_ctx_in.org[1] = i_ray.data.origin_y;
        w_ctx_in.org[2] = i_ray.data.origin_z;
        w_ctx_in.dir[0] = i_ray.data.direction_x;
        w_ctx_in.dir[1] = i_ray.data.direction_y;
        w_ctx_in.dir[2] = i_ray.data.direction_z;
        w_lo[0] = i_ray.data.box_low_x;
        w_lo[1] = i_ray.data.box_low_y;
        w_lo[2] = i_ray.data.box_low_z;
        w_hi[0] = i_ray.data.box_high_x;
        w_hi[1] = i_ray.data.box_high_y;
        w_hi[2] = i_ray.data.box_high_z;
    end

    // six plane dividers
    for (genvar a = 0; a < AXES; a++) begin : g_axis
        lbsi_div u_div_lo (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_corner (w_lo[a]),
            .i_origin (w_ctx_in.org[a]),
            .i_dir    (w_ctx_in.dir[a]),
            .i_high   (1'b0),
            .o_t      (w_tlo[a])
        );
        lbsi_div u_div_hi (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_corner (w_hi[a]),
            .i_origin (w_ctx_in.org[a]),
            .i_dir    (w_ctx_in.dir[a]),
            .i_high   (1'b1),
            .o_t      (w_thi[a])
        );
    end

    // tmin is the largest axis minimum, tmax the smallest axis maximum
    always_comb begin
        n_tmin = r_amin[0];
        n_tmax = r_amax[0];
        for (int a = 1; a < AXES; a++) begin
            if (r_amin[a] > n_tmin) begin
                n_tmin = r_amin[a];
            end
            if (r_amax[a] < n_tmax) begin
                n_tmax = r_amax[a];
            end
        end
    end

    // floor shift of the product, add origin, saturate
    function automatic t_coord point_sat(logic signed [PW-1:0] prod, t_coord org);
        logic signed [PW-FB:0] sum;
        sum = (PW-FB+1)'($signed(prod[PW-1:FB])) + (PW-FB+1)'(org);
        if (sum > (PW-FB+1)'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (sum < (PW-FB+1)'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return sum[CW-1:0];
    endfunction

    always_comb begin
        n_out.entry_x = point_sat(r_pmin[0], r_ctx[DIV_LAT+2].org[0]);
        n_out.entry_y = point_sat(r_pmin[1], r_ctx[DIV_LAT+2].org[1]);
        n_out.entry_z = point_sat(r_pmin[2], r_ctx[DIV_LAT+2].org[2]);
        n_out.exit_x  = point_sat(r_pmax[0], r_ctx[DIV_LAT+2].org[0]);
        n_out.exit_y  = point_sat(r_pmax[1], r_ctx[DIV_LAT+2].org[1]);
        n_out.exit_z  = point_sat(r_pmax[2], r_ctx[DIV_LAT+2].org[2]);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LEN-2:0], i_ray.valid};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctx[0] <= w_ctx_in;
            for (int k = 1; k <= DIV_LAT + 2; k++) begin
                r_ctx[k] <= r_ctx[k-1];
            end
            for (int a = 0; a < AXES; a++) begin
                r_amin[a] <= (w_tlo[a] < w_thi[a]) ? w_tlo[a] : w_thi[a];
                r_amax[a] <= (w_tlo[a] < w_thi[a]) ? w_thi[a] : w_tlo[a];
                r_pmin[a] <= PW'($signed(r_ctx[DIV_LAT+1].dir[a])) * PW'(r_tmin);
                r_pmax[a] <= PW'($signed(r_ctx[DIV_LAT+1].dir[a])) * PW'(r_tmax);
            end
            r_tmin <= n_tmin;
            r_tmax <= n_tmax;
            r_out  <= n_out;
        end
    end

    assign o_pts.valid = r_vld[PIPE_LEN-1];
    assign o_pts.data  = r_out;

    `ASSERT_CLK(a_in_enters, (i_ray.valid && i_ray.ready) |=> r_vld[0])
    `ASSERT_CLK(a_stall_freezes, (o_pts.valid && !o_pts.ready) |=> $stable(r_vld))
    `ASSERT_CLK(a_bubble_out, (!r_vld[PIPE_LEN-2] && i_ray.ready) |=> !o_pts.valid)
endmodule

/* sv/lbsi_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbsi_div
// pipelined plane parameter (corner - origin) * 2^FB / dir, one quotient bit
// per stage, truncated toward zero and saturated
// ----------------------------------------------------------------------------
module lbsi_div (
    input  logic            i_clk,
    input  logic            i_en,
    input  lbsi_pkg::t_coord i_corner,
    input  lbsi_pkg::t_coord i_origin,
    input  lbsi_pkg::t_coord i_dir,
    input  logic            i_high,
    output lbsi_pkg::t_coord o_t
);
    import lbsi_pkg::*;

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [NW-1:0] num;
        logic [CW-1:0] den;
        logic          neg;
        logic          zdir;
        t_coord        zval;
    } t_div_st;

    localparam logic [NW-1:0] LIM_POS = {{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [NW-1:0] LIM_NEG = LIM_POS + NW'(1);

    t_div_st r_st [0:NW];
    t_div_st n_st [0:NW];
    t_coord  r_t;
    t_coord  n_t;

    logic signed [CW:0] w_diff;
    logic [CW:0]        w_diff_mag;
    logic [CW-1:0]      w_dir_mag;

    // operand prep (exact difference, magnitudes, zero direction result),
    // then restoring division, one bit per stage
    always_comb begin
        logic [CW:0] rsh;
        logic [CW:0] sub;
        w_diff     = {i_corner[CW-1], i_corner} - {i_origin[CW-1], i_origin};
        w_diff_mag = w_diff[CW] ? -w_diff : w_diff;
        w_dir_mag  = i_dir[CW-1] ? -i_dir : i_dir;
        n_st[0].rem  = '0;
        n_st[0].num  = {w_diff_mag[CW-1:0], {FB{1'b0}}};
        n_st[0].den  = w_dir_mag;
        n_st[0].neg  = w_diff[CW] ^ i_dir[CW-1];
        n_st[0].zdir = (i_dir == '0);
        if ((!w_diff[CW] && w_diff != '0) || (i_high && w_diff == '0)) begin
            n_st[0].zval = WORD_MAX;
        end else begin
            n_st[0].zval = WORD_MIN;
        end
        for (int k = 1; k <= NW; k++) begin
            rsh = {r_st[k-1].rem, r_st[k-1].num[NW-1]};
            sub = rsh - {1'b0, r_st[k-1].den};
            n_st[k] = r_st[k-1];
            if (!sub[CW]) begin
                n_st[k].rem = sub[CW-1:0];
                n_st[k].num = {r_st[k-1].num[NW-2:0], 1'b1};
            end else begin
                n_st[k].rem = rsh[CW-1:0];
                n_st[k].num = {r_st[k-1].num[NW-2:0], 1'b0};
            end
        end
    end

    // sign and saturation of the quotient
    always_comb begin
        if (r_st[NW].zdir) begin
            n_t = r_st[NW].zval;
        end else if (r_st[NW].neg) begin
            n_t = (r_st[NW].num > LIM_NEG) ? WORD_MIN : -r_st[NW].num[CW-1:0];
        end else begin
            n_t = (r_st[NW].num > LIM_POS) ? WORD_MAX : r_st[NW].num[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= NW; k++) begin
                r_st[k] <= n_st[k];
            end
            r_t <= n_t;
        end
    end

    assign o_t = r_t;
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the slab clipper: random and corner-case rays and
// boxes go in, a local predictor works out entry and exit points, and each
// returned transaction is compared field by field in order
// ----------------------------------------------------------------------------
module tb_top;
    import lbsi_pkg::*;

    // expected point store and comparison
    class pts_scoreboard;
        t_pts   pending[$];
        int     n_bad;
        int     n_good;

        function void note_ray(t_pts expected_pts);
            pending.push_back(expected_pts);
        endfunction

        function void check_pts(t_pts got);
            t_pts want;
            if (pending.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (want !== got) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("mismatch entry exp %0d %0d %0d got %0d %0d %0d",
                             want.entry_x, want.entry_y, want.entry_z,
                             got.entry_x, got.entry_y, got.entry_z);
                    $display("         exit  exp %0d %0d %0d got %0d %0d %0d",
                             want.exit_x, want.exit_y, want.exit_z,
                             got.exit_x, got.exit_y, got.exit_z);
                end
            end else begin
                n_good++;
            end
        endfunction
    endclass

    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   send_idle_pct = 24;
    int   recv_idle_pct = 59;
    int   stall_cycles = 0;
    int   n_sent = 0;
    int   n_dir_zero = 0;
    int   n_miss = 0;
    bit   timed_out = 1'b0;
    pts_scoreboard sb;

    lbsi_ray_if i_ray ();
    lbsi_pts_if o_pts ();

    line_box_slab_intersection u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (i_ray),
        .o_pts   (o_pts)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // saturate a wide value to the coordinate range
    function automatic longint clamp_word(longint v);
        if (v > longint'(WORD_MAX)) return longint'(WORD_MAX);
        if (v < longint'(WORD_MIN)) return longint'(WORD_MIN);
        return v;
    endfunction

    // plane parameter for one corner along one axis
    function automatic longint slab_param(longint corner, longint org, longint dir,
                                          bit is_high);
        longint diff;
        diff = corner - org;
        if (dir == 0) begin
            if (diff > 0 || (is_high && diff == 0)) return longint'(WORD_MAX);
            return longint'(WORD_MIN);
        end
        return clamp_word((diff * (longint'(1) << FB)) / dir);
    endfunction

    // origin + direction * t, floor shift then saturate
    function automatic t_coord point_on_line(longint org, longint dir, longint t);
        longint p;
        p = (dir * t) >>> FB;
        return t_coord'(clamp_word(org + p));
    endfunction

    function automatic t_pts clip_points(t_ray r);
        longint o[3], d[3], lo[3], hi[3];
        longint ta, tb, amin, amax, tmin, tmax;
        t_pts res;
        o  = '{r.origin_x, r.origin_y, r.origin_z};
        d  = '{r.direction_x, r.direction_y, r.direction_z};
        lo = '{r.box_low_x, r.box_low_y, r.box_low_z};
        hi = '{r.box_high_x, r.box_high_y, r.box_high_z};
        tmin = 0;
        tmax = 0;
        for (int a = 0; a < AXES; a++) begin
            ta = slab_param(lo[a], o[a], d[a], 1'b0);
            tb = slab_param(hi[a], o[a], d[a], 1'b1);
            amin = (ta < tb) ? ta : tb;
            amax = (ta < tb) ? tb : ta;
            if (a == 0 || amin > tmin) tmin = amin;
            if (a == 0 || amax < tmax) tmax = amax;
        end
        if (tmin > tmax) n_miss++;
        res.entry_x = point_on_line(o[0], d[0], tmin);
        res.entry_y = point_on_line(o[1], d[1], tmin);
        res.entry_z = point_on_line(o[2], d[2], tmin);
        res.exit_x  = point_on_line(o[0], d[0], tmax);
        res.exit_y  = point_on_line(o[1], d[1], tmax);
        res.exit_z  = point_on_line(o[2], d[2], tmax);
        return res;
    endfunction

    // random coordinate: small values, corners, or full range
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3, 4: return t_coord'($urandom_range(0, 32'h000a_0000)) - 32'sh0005_0000;
            5: return t_coord'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            default: return t_coord'($urandom());
        endcase
    endfunction

    function automatic t_ray rand_ray();
        t_ray r;
        r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        if ($urandom_range(0, 3) != 0) begin
            r.origin_x = rand_coord();
            r.origin_y = rand_coord();
            r.origin_z = rand_coord();
            r.direction_x = ($urandom_range(0, 5) == 0) ? '0 : rand_coord();
            r.direction_y = ($urandom_range(0, 5) == 0) ? '0 : rand_coord();
            r.direction_z = ($urandom_range(0, 5) == 0) ? '0 : rand_coord();
            r.box_low_x = rand_coord();
            r.box_low_y = rand_coord();
            r.box_low_z = rand_coord();
            r.box_high_x = rand_coord();
            r.box_high_y = rand_coord();
            r.box_high_z = rand_coord();
        end
        return r;
    endfunction

    // offer one transaction, wait for acceptance; valid drops only in idle cycles
    task automatic send_ray(t_ray r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_ray.valid <= 1'b0;
            @(posedge i_clk);
        end
        i_ray.valid <= 1'b1;
        i_ray.data  <= r;
        sb.note_ray(clip_points(r));
        if (r.direction_x == 0 || r.direction_y == 0 || r.direction_z == 0)
            n_dir_zero++;
        n_sent++;
        do @(posedge i_clk); while (!i_ray.ready);
    endtask

    // unit-cube box with origin x and the direction set per axis; origin y/z at 0.5
    function automatic t_ray cube_ray(t_coord ox, t_coord dx, t_coord dy, t_coord dz);
        t_ray r;
        r = '{origin_x: ox, origin_y: 32'sh0000_8000, origin_z: 32'sh0000_8000,
              direction_x: dx, direction_y: dy, direction_z: dz,
              box_low_x: '0, box_low_y: '0, box_low_z: '0,
              box_high_x: 32'sh0001_0000, box_high_y: 32'sh0001_0000,
              box_high_z: 32'sh0001_0000};
        return r;
    endfunction

    task automatic run_directed();
        t_ray r;
        send_ray(cube_ray(-32'sh0002_0000, 32'sh0001_0000, 32'sh0000_2000, 32'sh0000_1000));
        send_ray(cube_ray(32'sh0002_0000, -32'sh0001_0000, 32'sh0000_0100, -32'sh0000_0100));
        // zero direction inside, on boundary, and outside the slab
        send_ray(cube_ray(32'sh0000_8000, 32'sh0001_0000, '0, '0));
        r = cube_ray(32'sh0000_8000, '0, 32'sh0001_0000, '0);
        r.origin_x = '0;
        send_ray(r);
        r.origin_x = 32'sh0001_0000;
        send_ray(r);
        r.origin_x = 32'sh0003_0000;
        send_ray(r);
        send_ray(cube_ray('0, '0, '0, '0));
        // miss: ray passes beside the box
        r = cube_ray(-32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, '0);
        r.origin_y = 32'sh0005_0000;
        send_ray(r);
        // inverted box
        r = cube_ray(-32'sh0002_0000, 32'sh0001_0000, 32'sh0000_4000, 32'sh0000_4000);
        r.box_low_x = 32'sh0001_0000;
        r.box_high_x = '0;
        send_ray(r);
        // extremes: saturating parameters and points
        r = '{default: WORD_MAX};
        send_ray(r);
        r = '{default: WORD_MIN};
        send_ray(r);
        r = '{default: '0};
        send_ray(r);
        r = cube_ray(WORD_MIN, 32'sh0000_0001, WORD_MAX, WORD_MIN);
        r.box_high_x = WORD_MAX;
        send_ray(r);
        r = cube_ray(WORD_MAX, -32'sh0000_0001, 32'sh0000_0001, -32'sh0000_0001);
        r.box_low_x = WORD_MIN;
        send_ray(r);
        r = '{default: -32'sh0000_0001};
        send_ray(r);
        r = '{default: 32'sh5555_5555};
        send_ray(r);
        r = '{default: 32'shaaaa_aaaa};
        send_ray(r);
    endtask

    // receiver: random stalls, check every output transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_pts.ready <= 1'b0;
        end else begin
            if (o_pts.valid && o_pts.ready) sb.check_pts(o_pts.data);
            o_pts.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_ray.valid && i_ray.ready) || (o_pts.valid && o_pts.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        sb = new();
        i_ray.valid = 1'b0;
        i_ray.data = '0;
        o_pts.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 24 : 0;
            repeat (260) send_ray(rand_ray());
        end
        i_ray.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("sent %0d rays (%0d with a zero direction axis, %0d misses)",
                 n_sent, n_dir_zero, n_miss);
        $display("checked %0d results, %0d bad", sb.n_good, sb.n_bad);
        if (sb.n_bad == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
